// File: rtl/core/iqh_pkg.sv
// ----------------------------------------------------------------------------
// Indexed min-heap queue package
// Sizes, request and status codes, node marks, sequencer states and the
// result record shared by the heap queue modules.
// ----------------------------------------------------------------------------
package iqh_pkg;

    localparam int HEAP_SLOTS    = 1023;
    localparam int NODE_COUNT    = 1024;
    localparam int NODE_W        = $clog2(NODE_COUNT);
    localparam int SLOT_W        = $clog2(HEAP_SLOTS);
    localparam int ENTRY_W       = $clog2(NODE_COUNT + 1);
    localparam int CNT_W         = $clog2(HEAP_SLOTS + 1);
    localparam int CHILD_W       = SLOT_W + 2;
    localparam int WEIGHT_W      = 32;
    localparam int PAYLOAD_W     = 32;
    localparam int KIND_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int NODE_FIELD_W  = 10;
    localparam int COUNT_FIELD_W = 10;
    localparam int IN_DATA_W     = 80;
    localparam int OUT_DATA_W    = 88;

    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

    localparam logic [1:0] NS_NEW    = 2'd0;
    localparam logic [1:0] NS_QUEUED = 2'd1;
    localparam logic [1:0] NS_DONE   = 2'd2;

    localparam logic [ENTRY_W-1:0] SLOT_EMPTY = ENTRY_W'(NODE_COUNT);

    typedef enum logic [4:0] {
        S_SWEEP,
        S_IDLE,
        S_ADD0,
        S_ADD1,
        S_UP0,
        S_UP1,
        S_UP2,
        S_PLACE,
        S_POP0,
        S_POP1,
        S_POP2,
        S_DN0,
        S_DN1,
        S_DN2,
        S_DN3,
        S_DN4,
        S_MOVE,
        S_HOLE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [NODE_FIELD_W-1:0]  node;
        logic [WEIGHT_W-1:0]      weight;
        logic [PAYLOAD_W-1:0]     payload;
        logic [COUNT_FIELD_W-1:0] count;
    } res_t;

endpackage

// File: rtl/core/indexed_min_heap_queue_core.sv
// ----------------------------------------------------------------------------
// Indexed min-heap queue core
// Node-indexed binary min-heap with add-or-lower-key, pop-minimum and clear.
//
//   Channel   Direction  Fields
//   s_axis    in         tuser: kind; tdata: node, new_weight, payload
//   m_axis    out        tuser: status; tdata: popped_node, popped_weight,
//                        popped_payload, queued_count
//
// An add climbs and a pop descends the heap level by level, paced by the one
// heap-slot memory read port. A clear walks the node-mark memory one node per
// cycle over all 1024 nodes; the same pass runs after reset. A finished result
// waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // node, new_weight, payload
    input  logic [1:0]  s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,  // popped_node, popped_weight,
                                       // popped_payload, queued_count
    output logic [1:0]  m_axis_tuser   // status
);

    import iqh_pkg::*;

    logic res_valid;
    logic res_ready;
    res_t res;
    logic out_valid_reg;
    res_t out_reg;

    iqh_seq u_seq (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .in_kind(s_axis_tuser),
        .in_node(s_axis_tdata[9:0]),
        .in_weight(s_axis_tdata[41:10]),
        .in_payload(s_axis_tdata[73:42]),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {4'b0, out_reg.count, out_reg.payload, out_reg.weight,
                            out_reg.node};

    a_full_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ST_FULL |->
        m_axis_tdata[83:74] == COUNT_FIELD_W'(HEAP_SLOTS))
        else $error("full status with spare capacity");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[83:74] <= COUNT_FIELD_W'(HEAP_SLOTS))
        else $error("queued count beyond heap size");

    a_failed_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ST_EMPTY |->
        m_axis_tdata[73:0] == '0)
        else $error("empty pop returned a node");

endmodule

// File: rtl/core/iqh_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module iqh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/iqh_cmp.sv
// ----------------------------------------------------------------------------
// Heap queue weight comparator
// The one less-than unit, shared by the add key check, sift-up and the walk down.
// ----------------------------------------------------------------------------
module iqh_cmp (
    input  logic                          sel_walk,
    input  logic [iqh_pkg::WEIGHT_W-1:0]  a_add,
    input  logic [iqh_pkg::WEIGHT_W-1:0]  a_walk,
    input  logic [iqh_pkg::WEIGHT_W-1:0]  b,
    output logic                          less
);

    import iqh_pkg::*;

    logic [WEIGHT_W-1:0] a;

    assign a    = sel_walk ? a_walk : a_add;
    assign less = a < b;

endmodule

// File: rtl/core/iqh_seq.sv
// ----------------------------------------------------------------------------
// Heap queue sequencer
// Holds the heap stores and steps through add, pop and clear requests one
// memory access at a time.
// ----------------------------------------------------------------------------
module iqh_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [iqh_pkg::KIND_W-1:0]     in_kind,
    input  logic [iqh_pkg::NODE_W-1:0]     in_node,
    input  logic [iqh_pkg::WEIGHT_W-1:0]   in_weight,
    input  logic [iqh_pkg::PAYLOAD_W-1:0]  in_payload,
    output logic                           res_valid,
    input  logic                           res_ready,
    output iqh_pkg::res_t                  res
);

    import iqh_pkg::*;

    localparam int ND_W = WEIGHT_W + PAYLOAD_W;

    state_t               state_reg, state_next;
    logic [NODE_W-1:0]    node_reg, node_next;
    logic [WEIGHT_W-1:0]  w_reg, w_next;
    logic [PAYLOAD_W-1:0] pl_reg, pl_next;
    logic [CNT_W-1:0]     ec_reg, ec_next;
    logic [CNT_W-1:0]     fc_reg, fc_next;
    logic [SLOT_W-1:0]    h_reg, h_next;
    logic [SLOT_W-1:0]    p_reg, p_next;
    logic [CHILD_W-1:0]   l_reg, l_next;
    logic [ENTRY_W-1:0]   lq_reg, lq_next;
    logic [ENTRY_W-1:0]   rq_reg, rq_next;
    logic                 l_occ_reg, l_occ_next;
    logic                 right_reg, right_next;
    logic [WEIGHT_W-1:0]  lw_reg, lw_next;
    logic [NODE_W-1:0]    first_reg, first_next;
    logic [WEIGHT_W-1:0]  pw_reg, pw_next;
    logic [PAYLOAD_W-1:0] pp_reg, pp_next;
    logic                 popped_reg, popped_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [NODE_W-1:0]    sweep_cnt_reg, sweep_cnt_next;
    logic                 sweep_item_reg, sweep_item_next;

    logic                 hs_we;
    logic [SLOT_W-1:0]    hs_waddr, hs_raddr;
    logic [ENTRY_W-1:0]   hs_wdata, hs_rdata;
    logic                 pos_we;
    logic [NODE_W-1:0]    pos_waddr, pos_raddr;
    logic [SLOT_W-1:0]    pos_wdata, pos_rdata;
    logic                 nd_we;
    logic [NODE_W-1:0]    nd_waddr, nd_raddr;
    logic [ND_W-1:0]      nd_wdata, nd_rdata;
    logic                 st_we;
    logic [NODE_W-1:0]    st_waddr, st_raddr;
    logic [1:0]           st_wdata, st_rdata;
    logic                 fs_we;
    logic [SLOT_W-1:0]    fs_waddr, fs_raddr;
    logic [SLOT_W-1:0]    fs_wdata, fs_rdata;

    logic                 cmp_sel_walk;
    logic                 cmp_less;
    logic                 add_new;
    logic [CHILD_W-1:0]   hwm;
    logic [CHILD_W-1:0]   l_now;
    logic [CHILD_W-1:0]   r_now;
    logic                 r_occ;

    iqh_ram #(.WIDTH(ENTRY_W), .DEPTH(HEAP_SLOTS)) u_heap_slots (
        .clk(clk), .we(hs_we), .waddr(hs_waddr), .wdata(hs_wdata),
        .raddr(hs_raddr), .rdata(hs_rdata)
    );

    iqh_ram #(.WIDTH(SLOT_W), .DEPTH(NODE_COUNT)) u_node_position (
        .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
        .raddr(pos_raddr), .rdata(pos_rdata)
    );

    iqh_ram #(.WIDTH(ND_W), .DEPTH(NODE_COUNT)) u_node_data (
        .clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
        .raddr(nd_raddr), .rdata(nd_rdata)
    );

    iqh_ram #(.WIDTH(2), .DEPTH(NODE_COUNT)) u_node_status (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );

    iqh_ram #(.WIDTH(SLOT_W), .DEPTH(HEAP_SLOTS)) u_free_stack (
        .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
        .raddr(fs_raddr), .rdata(fs_rdata)
    );

    iqh_cmp u_cmp (
        .sel_walk(cmp_sel_walk),
        .a_add(w_reg),
        .a_walk(lw_reg),
        .b(nd_rdata[ND_W-1:PAYLOAD_W]),
        .less(cmp_less)
    );

    // Slots at or above the high-water mark have not been written since the
    // last clear, so they count as empty.
    assign hwm   = CHILD_W'(ec_reg) + CHILD_W'(fc_reg);
    assign l_now = CHILD_W'({h_reg, 1'b1});
    assign r_now = l_reg + CHILD_W'(1);
    assign r_occ = (r_now < CHILD_W'(HEAP_SLOTS)) && (r_now < hwm) &&
                   (hs_rdata < SLOT_EMPTY);

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            ec_reg         <= '0;
            fc_reg         <= '0;
            sweep_cnt_reg  <= '0;
            sweep_item_reg <= 1'b0;
            popped_reg     <= 1'b0;
            status_reg     <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            ec_reg         <= ec_next;
            fc_reg         <= fc_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            sweep_item_reg <= sweep_item_next;
            popped_reg     <= popped_next;
            status_reg     <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        w_reg     <= w_next;
        pl_reg    <= pl_next;
        h_reg     <= h_next;
        p_reg     <= p_next;
        l_reg     <= l_next;
        lq_reg    <= lq_next;
        rq_reg    <= rq_next;
        l_occ_reg <= l_occ_next;
        right_reg <= right_next;
        lw_reg    <= lw_next;
        first_reg <= first_next;
        pw_reg    <= pw_next;
        pp_reg    <= pp_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        node_next       = node_reg;
        w_next          = w_reg;
        pl_next         = pl_reg;
        ec_next         = ec_reg;
        fc_next         = fc_reg;
        h_next          = h_reg;
        p_next          = p_reg;
        l_next          = l_reg;
        lq_next         = lq_reg;
        rq_next         = rq_reg;
        l_occ_next      = l_occ_reg;
        right_next      = right_reg;
        lw_next         = lw_reg;
        first_next      = first_reg;
        pw_next         = pw_reg;
        pp_next         = pp_reg;
        popped_next     = popped_reg;
        status_next     = status_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        sweep_item_next = sweep_item_reg;

        hs_we     = 1'b0;
        hs_waddr  = h_reg;
        hs_wdata  = SLOT_EMPTY;
        hs_raddr  = '0;
        pos_we    = 1'b0;
        pos_waddr = node_reg;
        pos_wdata = h_reg;
        pos_raddr = node_reg;
        nd_we     = 1'b0;
        nd_waddr  = node_reg;
        nd_wdata  = {w_reg, pl_reg};
        nd_raddr  = node_reg;
        st_we     = 1'b0;
        st_waddr  = node_reg;
        st_wdata  = NS_NEW;
        st_raddr  = node_reg;
        fs_we     = 1'b0;
        fs_waddr  = SLOT_W'(fc_reg);
        fs_wdata  = h_reg;
        fs_raddr  = SLOT_W'(fc_reg - CNT_W'(1));

        cmp_sel_walk = 1'b0;
        add_new      = 1'b0;
        res_valid    = 1'b0;

        case (state_reg)
            S_SWEEP:
            begin
                st_we          = 1'b1;
                st_waddr       = sweep_cnt_reg;
                st_wdata       = NS_NEW;
                sweep_cnt_next = sweep_cnt_reg + NODE_W'(1);
                if (sweep_cnt_reg == NODE_W'(NODE_COUNT - 1))
                begin
                    state_next = sweep_item_reg ? S_DONE : S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    node_next   = in_node;
                    w_next      = in_weight;
                    pl_next     = in_payload;
                    popped_next = 1'b0;
                    status_next = ST_OK;
                    case (in_kind)
                        KIND_ADD:   state_next = S_ADD0;
                        KIND_POP:   state_next = S_POP0;
                        KIND_CLEAR:
                        begin
                            ec_next         = '0;
                            fc_next         = '0;
                            sweep_cnt_next  = '0;
                            sweep_item_next = 1'b1;
                            state_next      = S_SWEEP;
                        end
                        default:    state_next = S_DONE;
                    endcase
                end
            end

            S_ADD0:
            begin
                state_next = S_ADD1;
            end

            S_ADD1:
            begin
                case (st_rdata)
                    NS_NEW:
                    begin
                        if (fc_reg != '0)
                        begin
                            h_next  = fs_rdata;
                            fc_next = fc_reg - CNT_W'(1);
                            add_new = 1'b1;
                        end
                        else if (ec_reg >= CNT_W'(HEAP_SLOTS))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            h_next  = SLOT_W'(ec_reg);
                            add_new = 1'b1;
                        end
                        if (add_new)
                        begin
                            ec_next    = ec_reg + CNT_W'(1);
                            st_we      = 1'b1;
                            st_wdata   = NS_QUEUED;
                            nd_we      = 1'b1;
                            state_next = S_UP0;
                        end
                    end
                    NS_QUEUED:
                    begin
                        if (cmp_less)
                        begin
                            nd_we      = 1'b1;
                            h_next     = pos_rdata;
                            state_next = S_UP0;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    NS_DONE:
                    begin
                        status_next = ST_IGNORED;
                        state_next  = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_UP0:
            begin
                if (h_reg == '0)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    p_next     = (h_reg - SLOT_W'(1)) >> 1;
                    hs_raddr   = (h_reg - SLOT_W'(1)) >> 1;
                    state_next = S_UP1;
                end
            end

            S_UP1:
            begin
                if (hs_rdata >= SLOT_EMPTY)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    lq_next    = hs_rdata;
                    nd_raddr   = hs_rdata[NODE_W-1:0];
                    state_next = S_UP2;
                end
            end

            S_UP2:
            begin
                if (cmp_less)
                begin
                    hs_we      = 1'b1;
                    hs_wdata   = lq_reg;
                    pos_we     = 1'b1;
                    pos_waddr  = lq_reg[NODE_W-1:0];
                    h_next     = p_reg;
                    state_next = S_UP0;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end

            S_PLACE:
            begin
                hs_we      = 1'b1;
                hs_wdata   = ENTRY_W'(node_reg);
                pos_we     = 1'b1;
                state_next = S_DONE;
            end

            S_POP0:
            begin
                if (ec_reg == '0)
                begin
                    status_next = ST_EMPTY;
                    state_next  = S_DONE;
                end
                else
                begin
                    hs_raddr   = '0;
                    state_next = S_POP1;
                end
            end

            S_POP1:
            begin
                if (hs_rdata >= SLOT_EMPTY)
                begin
                    status_next = ST_EMPTY;
                    state_next  = S_DONE;
                end
                else
                begin
                    first_next = hs_rdata[NODE_W-1:0];
                    nd_raddr   = hs_rdata[NODE_W-1:0];
                    h_next     = '0;
                    state_next = S_POP2;
                end
            end

            S_POP2:
            begin
                pw_next     = nd_rdata[ND_W-1:PAYLOAD_W];
                pp_next     = nd_rdata[PAYLOAD_W-1:0];
                popped_next = 1'b1;
                st_we       = 1'b1;
                st_waddr    = first_reg;
                st_wdata    = NS_DONE;
                state_next  = S_DN0;
            end

            S_DN0:
            begin
                if (l_now >= CHILD_W'(HEAP_SLOTS))
                begin
                    state_next = S_HOLE;
                end
                else
                begin
                    l_next     = l_now;
                    hs_raddr   = l_now[SLOT_W-1:0];
                    state_next = S_DN1;
                end
            end

            S_DN1:
            begin
                lq_next    = hs_rdata;
                l_occ_next = (l_reg < hwm) && (hs_rdata < SLOT_EMPTY);
                hs_raddr   = r_now[SLOT_W-1:0];
                state_next = S_DN2;
            end

            S_DN2:
            begin
                rq_next = hs_rdata;
                if (!l_occ_reg && !r_occ)
                begin
                    state_next = S_HOLE;
                end
                else if (!r_occ)
                begin
                    right_next = 1'b0;
                    state_next = S_MOVE;
                end
                else if (!l_occ_reg)
                begin
                    right_next = 1'b1;
                    state_next = S_MOVE;
                end
                else
                begin
                    nd_raddr   = lq_reg[NODE_W-1:0];
                    state_next = S_DN3;
                end
            end

            S_DN3:
            begin
                lw_next    = nd_rdata[ND_W-1:PAYLOAD_W];
                nd_raddr   = rq_reg[NODE_W-1:0];
                state_next = S_DN4;
            end

            S_DN4:
            begin
                cmp_sel_walk = 1'b1;
                right_next   = !cmp_less;
                state_next   = S_MOVE;
            end

            S_MOVE:
            begin
                hs_we      = 1'b1;
                hs_wdata   = right_reg ? rq_reg : lq_reg;
                pos_we     = 1'b1;
                pos_waddr  = right_reg ? rq_reg[NODE_W-1:0] : lq_reg[NODE_W-1:0];
                h_next     = right_reg ? r_now[SLOT_W-1:0] : l_reg[SLOT_W-1:0];
                state_next = S_DN0;
            end

            S_HOLE:
            begin
                hs_we      = 1'b1;
                hs_wdata   = SLOT_EMPTY;
                fs_we      = 1'b1;
                fc_next    = fc_reg + CNT_W'(1);
                ec_next    = ec_reg - CNT_W'(1);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.status  = status_reg;
        res.node    = popped_reg ? NODE_FIELD_W'(first_reg) : '0;
        res.weight  = popped_reg ? pw_reg : '0;
        res.payload = popped_reg ? pp_reg : '0;
        res.count   = COUNT_FIELD_W'(ec_reg);
    end

endmodule
